FILE: src/hgp_pkg.sv
package hgp_pkg;

	// field widths fixed by the register map and result format
	localparam int CAM_W      = 13;
	localparam int SCR_W      = 14;
	localparam int MRG_W      = 10;
	localparam int ALPHA_W    = 9;
	localparam int MASK_W     = 5;
	localparam int CLICK_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	// internal arithmetic widths
	localparam int SPAN_W     = CAM_W + 2;
	localparam int ACC_W      = CAM_W + SCR_W + 1;
	localparam int NUM_W      = ACC_W + 1;
	localparam int CUR_W      = SCR_W + 3;
	localparam int FRAC_SHIFT = 8;
	localparam int DIV_STEPS  = SCR_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	// register reset values
	localparam logic [SCR_W-1:0]   SCREEN_W_RST = 14'd1920;
	localparam logic [SCR_W-1:0]   SCREEN_H_RST = 14'd1080;
	localparam logic [CAM_W-1:0]   CAMERA_W_RST = 13'd640;
	localparam logic [CAM_W-1:0]   CAMERA_H_RST = 13'd480;
	localparam logic [MRG_W-1:0]   MARGIN_RST   = 10'd100;
	localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd128;

	// finger patterns, bit0 thumb through bit4 little finger
	localparam logic [MASK_W-1:0] PAT_LEFT      = 5'b00001;
	localparam logic [MASK_W-1:0] PAT_RIGHT     = 5'b10011;
	localparam logic [MASK_W-1:0] PAT_SCROLL_DN = 5'b00000;
	localparam logic [MASK_W-1:0] PAT_SCROLL_UP = 5'b10000;
	localparam logic [MASK_W-1:0] PAT_MOVE      = 5'b00010;
	localparam logic [MASK_W-1:0] PAT_DRAG      = 5'b00110;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCREEN_W = 3'd0,
		REG_SCREEN_H = 3'd1,
		REG_CAMERA_W = 3'd2,
		REG_CAMERA_H = 3'd3,
		REG_MARGIN   = 3'd4,
		REG_ALPHA    = 3'd5
	} cfg_reg_t;

	typedef enum logic [CLICK_W-1:0] {
		CLICK_NONE      = 3'd0,
		CLICK_LEFT      = 3'd1,
		CLICK_RIGHT     = 3'd2,
		CLICK_SCROLL_DN = 3'd3,
		CLICK_SCROLL_UP = 3'd4
	} click_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LC,
		ST_HS,
		ST_LS,
		ST_BS,
		ST_NUM,
		ST_DCHK,
		ST_DIV,
		ST_SMI,
		ST_SMA,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic [MASK_W-1:0] mask;
		click_t            click;
		logic              drag;
		logic              want_move;
	} gesture_t;

endpackage

FILE: src/hgp_if.sv
interface hgp_in_if #(parameter int LANDMARK_BITS = 16);
	logic                     valid;
	logic                     ready;
	logic [LANDMARK_BITS-1:0] thumb_tip_x;
	logic [LANDMARK_BITS-1:0] thumb_joint_x;
	logic [LANDMARK_BITS-1:0] index_tip_x;
	logic [LANDMARK_BITS-1:0] index_tip_y;
	logic [LANDMARK_BITS-1:0] index_joint_y;
	logic [LANDMARK_BITS-1:0] middle_tip_y;
	logic [LANDMARK_BITS-1:0] middle_joint_y;
	logic [LANDMARK_BITS-1:0] ring_tip_y;
	logic [LANDMARK_BITS-1:0] ring_joint_y;
	logic [LANDMARK_BITS-1:0] pinky_tip_y;
	logic [LANDMARK_BITS-1:0] pinky_joint_y;
	logic                     hand_is_right;

	modport source (
		output valid, thumb_tip_x, thumb_joint_x, index_tip_x, index_tip_y, index_joint_y,
		       middle_tip_y, middle_joint_y, ring_tip_y, ring_joint_y, pinky_tip_y,
		       pinky_joint_y, hand_is_right,
		input  ready
	);
	modport sink (
		input  valid, thumb_tip_x, thumb_joint_x, index_tip_x, index_tip_y, index_joint_y,
		       middle_tip_y, middle_joint_y, ring_tip_y, ring_joint_y, pinky_tip_y,
		       pinky_joint_y, hand_is_right,
		output ready
	);
endinterface

interface hgp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  click_code;
	logic        press_left;
	logic        release_left;
	logic        move_valid;
	logic [13:0] cursor_x;
	logic [13:0] cursor_y;
	logic [4:0]  finger_mask;

	modport source (
		output valid, click_code, press_left, release_left, move_valid, cursor_x, cursor_y,
		       finger_mask,
		input  ready
	);
	modport sink (
		input  valid, click_code, press_left, release_left, move_valid, cursor_x, cursor_y,
		       finger_mask,
		output ready
	);
endinterface

interface hgp_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [13:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: src/hand_gesture_to_pointer_events.sv
// A frame without a move passes from ST_IDLE through ST_DONE to the result register; a move or drag
// frame runs each axis through the shared multiplier and a 14-step restoring divider,
// whose steps are skipped when the divide saturates or the target falls below zero.
// One frame is in work at a time: a new request is taken only after the last result is loaded.
// Reset: arst_n clears the sequencer, the kept cursor and the held button and loads
// the register defaults; the result channel comes up empty.
module hand_gesture_to_pointer_events
	import hgp_pkg::*;
#(
	parameter int LANDMARK_BITS = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	hgp_in_if.sink     in_ch,
	hgp_out_if.source  out_ch,
	hgp_cfg_if.sink    cfg_ch
);

	localparam int LB = LANDMARK_BITS;
	localparam int MA = ((LB > SCR_W + 1) ? LB : SCR_W + 1) + 1;
	localparam int MB = SCR_W + 1;
	localparam int PW = MA + MB;

	// configuration registers
	logic [SCR_W-1:0]   scr_w_q, scr_h_q;
	logic [CAM_W-1:0]   cam_w_q, cam_h_q;
	logic [MRG_W-1:0]   margin_q;
	logic [ALPHA_W-1:0] alpha_q;

	// sequencer and per-frame registers
	seq_state_t           state_q, state_d;
	gesture_t             gest, gest_q;
	logic [LB-1:0]        lx_q, ly_q, lo_q;
	logic                 axis_q, press_q, release_q, move_q, held_q;
	logic [ACC_W-1:0]     acc_q;
	logic                 rnd_q;
	logic [NUM_W-1:0]     num_q;
	logic [SCR_W-1:0]     rem_q, low_q, quo_q, tgt_q, res_x_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SCR_W-1:0]     cur_x_q, cur_y_q;

	// result register
	logic                 out_valid_q;
	click_t               out_click_q;
	logic                 out_press_q, out_release_q, out_move_q;
	logic [SCR_W-1:0]     out_cx_q, out_cy_q;
	logic [MASK_W-1:0]    out_mask_q;

	// handshake and datapath controls
	logic                 in_fire, out_free, span_zero, div_last, div_ovf;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] prod_q;

	// axis selection
	logic [LB-1:0]        lm_a;
	logic [CAM_W-1:0]     cam_a, dsor;
	logic [SCR_W-1:0]     scr_a, prev_a;
	logic [SPAN_W-1:0]    span, span_abs;
	logic                 span_neg;
	logic [ALPHA_W-1:0]   alpha_eff;
	logic [NUM_W-1:0]     num_d;
	logic [SCR_W:0]       trial;
	logic                 trial_ge;
	logic [SCR_W-1:0]     rem_d, quo_d;
	logic [SCR_W:0]       diff;
	logic [CUR_W-1:0]     cur, step;
	logic [SCR_W-1:0]     cur_sat;

	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign cfg_ch.ready = 1'b1;

	hgp_gesture #(.LB(LB)) u_gesture (
		.thumb_tip_x    (in_ch.thumb_tip_x),
		.thumb_joint_x  (in_ch.thumb_joint_x),
		.index_tip_y    (in_ch.index_tip_y),
		.index_joint_y  (in_ch.index_joint_y),
		.middle_tip_y   (in_ch.middle_tip_y),
		.middle_joint_y (in_ch.middle_joint_y),
		.ring_tip_y     (in_ch.ring_tip_y),
		.ring_joint_y   (in_ch.ring_joint_y),
		.pinky_tip_y    (in_ch.pinky_tip_y),
		.pinky_joint_y  (in_ch.pinky_joint_y),
		.hand_is_right  (in_ch.hand_is_right),
		.gest           (gest)
	);

	hgp_mul #(.AW(MA), .BW(MB)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod_q)
	);

	// per-axis operands
	always_comb begin
		lm_a      = axis_q ? ly_q : lx_q;
		cam_a     = axis_q ? cam_h_q : cam_w_q;
		scr_a     = axis_q ? scr_h_q : scr_w_q;
		prev_a    = axis_q ? cur_y_q : cur_x_q;
		span      = SPAN_W'(cam_a) - SPAN_W'({margin_q, 1'b0});
		span_neg  = span[SPAN_W-1];
		span_abs  = span_neg ? (SPAN_W'(0) - span) : span;
		dsor      = span_abs[CAM_W-1:0];
		alpha_eff = alpha_q[ALPHA_W-1] ? ALPHA_ONE : alpha_q;
		span_zero = (cam_w_q == CAM_W'({margin_q, 1'b0})) ||
		            (cam_h_q == CAM_W'({margin_q, 1'b0}));
	end

	// numerator of the floored quotient, sign folded by the span sign
	always_comb begin
		if (span_neg) begin
			num_d = NUM_W'(prod_q[MRG_W+SCR_W-1:0]) - NUM_W'(acc_q) - NUM_W'(rnd_q);
		end else begin
			num_d = NUM_W'(acc_q) - NUM_W'(prod_q[MRG_W+SCR_W-1:0]);
		end
	end

	// one restoring divide step
	always_comb begin
		trial    = {rem_q, low_q[SCR_W-1]};
		trial_ge = trial >= (SCR_W+1)'(dsor);
		rem_d    = trial_ge ? SCR_W'(trial - (SCR_W+1)'(dsor)) : SCR_W'(trial);
		quo_d    = {quo_q[SCR_W-2:0], trial_ge};
		div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
		div_ovf  = num_q[NUM_W-2:SCR_W] >= SCR_W'(dsor);
	end

	// smoothing: prev + floor((tgt - prev) * a / 256), clamped to the screen
	always_comb begin
		diff = (SCR_W+1)'(tgt_q) - (SCR_W+1)'(prev_a);
		step = CUR_W'(prod_q[PW-1:FRAC_SHIFT]);
		cur  = CUR_W'(prev_a) + step;
		if (cur[CUR_W-1]) begin
			cur_sat = '0;
		end else if (cur[CUR_W-2:0] > (CUR_W-1)'(scr_a)) begin
			cur_sat = scr_a;
		end else begin
			cur_sat = cur[SCR_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (gest.want_move && !span_zero) ? ST_LC : ST_DONE;
				end
			end
			ST_LC:   state_d = ST_HS;
			ST_HS:   state_d = ST_LS;
			ST_LS:   state_d = ST_BS;
			ST_BS:   state_d = ST_NUM;
			ST_NUM:  state_d = ST_DCHK;
			ST_DCHK: begin
				state_d = (num_q[NUM_W-1] || div_ovf) ? ST_SMI : ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_SMI;
				end
			end
			ST_SMI:  state_d = ST_SMA;
			ST_SMA:  state_d = axis_q ? ST_DONE : ST_LC;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: request ready and multiplier operands
	always_comb begin
		in_ch.ready = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_LC: begin
				mul_a = $signed(MA'(lm_a));
				mul_b = $signed(MB'(cam_a));
			end
			ST_HS: begin
				mul_a = $signed(MA'(prod_q[LB+CAM_W-1:LB]));
				mul_b = $signed(MB'(scr_a));
			end
			ST_LS: begin
				mul_a = $signed(MA'(lo_q));
				mul_b = $signed(MB'(scr_a));
			end
			ST_BS: begin
				mul_a = $signed(MA'(margin_q));
				mul_b = $signed(MB'(scr_a));
			end
			ST_SMI: begin
				mul_a = MA'($signed(diff));
				mul_b = $signed(MB'(alpha_eff));
			end
			default: begin
				in_ch.ready = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= 1'b0;
			held_q      <= 1'b0;
			move_q      <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			out_valid_q <= 1'b0;
			scr_w_q     <= SCREEN_W_RST;
			scr_h_q     <= SCREEN_H_RST;
			cam_w_q     <= CAMERA_W_RST;
			cam_h_q     <= CAMERA_H_RST;
			margin_q    <= MARGIN_RST;
			alpha_q     <= ALPHA_RST;
		end else begin
			state_q <= state_d;

			// register writes
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_SCREEN_W: scr_w_q  <= cfg_ch.data[SCR_W-1:0];
					REG_SCREEN_H: scr_h_q  <= cfg_ch.data[SCR_W-1:0];
					REG_CAMERA_W: cam_w_q  <= cfg_ch.data[CAM_W-1:0];
					REG_CAMERA_H: cam_h_q  <= cfg_ch.data[CAM_W-1:0];
					REG_MARGIN:   margin_q <= cfg_ch.data[MRG_W-1:0];
					REG_ALPHA:    alpha_q  <= cfg_ch.data[ALPHA_W-1:0];
					default:      ;
				endcase
			end

			// button hold follows the drag pattern
			if (state_q == ST_IDLE && in_fire) begin
				axis_q <= 1'b0;
				move_q <= 1'b0;
				held_q <= gest.drag;
			end

			// both axes done: commit the cursor
			if (state_q == ST_SMA) begin
				axis_q <= 1'b1;
				if (axis_q) begin
					cur_x_q <= res_x_q;
					cur_y_q <= cur_sat;
					move_q  <= 1'b1;
				end
			end

			// result register fills from the sequencer, drains on the handshake
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.valid && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					lx_q      <= in_ch.index_tip_x;
					ly_q      <= in_ch.index_tip_y;
					gest_q    <= gest;
					press_q   <= gest.drag && !held_q;
					release_q <= !gest.drag && held_q;
				end
			end
			ST_HS:  lo_q  <= prod_q[LB-1:0];
			ST_LS:  acc_q <= prod_q[ACC_W-1:0];
			ST_BS: begin
				acc_q <= acc_q + ACC_W'(prod_q[LB+SCR_W-1:LB]);
				rnd_q <= |prod_q[LB-1:0];
			end
			ST_NUM: num_q <= num_d;
			ST_DCHK: begin
				// negative target clamps to zero, a quotient past the screen to the edge
				if (num_q[NUM_W-1]) begin
					tgt_q <= '0;
				end else if (div_ovf) begin
					tgt_q <= scr_a;
				end
				rem_q <= num_q[NUM_W-2:SCR_W];
				low_q <= num_q[SCR_W-1:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_d;
				low_q <= {low_q[SCR_W-2:0], 1'b0};
				quo_q <= quo_d;
				cnt_q <= cnt_q + CNT_W'(1);
				if (div_last) begin
					tgt_q <= (quo_d > scr_a) ? scr_a : quo_d;
				end
			end
			ST_SMA: begin
				if (!axis_q) begin
					res_x_q <= cur_sat;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_click_q   <= gest_q.click;
					out_press_q   <= press_q;
					out_release_q <= release_q;
					out_move_q    <= move_q;
					out_cx_q      <= cur_x_q;
					out_cy_q      <= cur_y_q;
					out_mask_q    <= gest_q.mask;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.click_code   = out_click_q;
	assign out_ch.press_left   = out_press_q;
	assign out_ch.release_left = out_release_q;
	assign out_ch.move_valid   = out_move_q;
	assign out_ch.cursor_x     = out_cx_q;
	assign out_ch.cursor_y     = out_cy_q;
	assign out_ch.finger_mask  = out_mask_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("request taken while a frame is in work");

	a_press_release_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !(out_ch.press_left && out_ch.release_left))
		else $error("press and release in one result");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.move_valid |->
		(out_ch.cursor_x <= scr_w_q) && (out_ch.cursor_y <= scr_h_q))
		else $error("moved cursor outside the screen");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < SCR_W'(dsor))
		else $error("divider remainder not below divisor");
`endif

endmodule

FILE: src/hgp_mul.sv
module hgp_mul
	import hgp_pkg::*;
#(
	parameter int AW = 17,
	parameter int BW = 15
) (
	input  logic                    clk,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);

	// shared signed multiplier, product registered for the next step
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

FILE: src/hgp_gesture.sv
module hgp_gesture
	import hgp_pkg::*;
#(
	parameter int LB = 16
) (
	input  logic [LB-1:0] thumb_tip_x,
	input  logic [LB-1:0] thumb_joint_x,
	input  logic [LB-1:0] index_tip_y,
	input  logic [LB-1:0] index_joint_y,
	input  logic [LB-1:0] middle_tip_y,
	input  logic [LB-1:0] middle_joint_y,
	input  logic [LB-1:0] ring_tip_y,
	input  logic [LB-1:0] ring_joint_y,
	input  logic [LB-1:0] pinky_tip_y,
	input  logic [LB-1:0] pinky_joint_y,
	input  logic          hand_is_right,
	output gesture_t      gest
);

	logic [MASK_W-1:0] mask;

	// raised fingers: thumb by x depending on hand, others tip above joint
	always_comb begin
		mask[0] = hand_is_right ? (thumb_tip_x > thumb_joint_x) : (thumb_tip_x < thumb_joint_x);
		mask[1] = index_tip_y < index_joint_y;
		mask[2] = middle_tip_y < middle_joint_y;
		mask[3] = ring_tip_y < ring_joint_y;
		mask[4] = pinky_tip_y < pinky_joint_y;
	end

	// pattern decode
	always_comb begin
		gest.mask      = mask;
		gest.drag      = (mask == PAT_DRAG);
		gest.want_move = (mask == PAT_MOVE) || (mask == PAT_DRAG);
		case (mask)
			PAT_LEFT:      gest.click = CLICK_LEFT;
			PAT_RIGHT:     gest.click = CLICK_RIGHT;
			PAT_SCROLL_DN: gest.click = CLICK_SCROLL_DN;
			PAT_SCROLL_UP: gest.click = CLICK_SCROLL_UP;
			default:       gest.click = CLICK_NONE;
		endcase
	end

endmodule
